/* rtl/grid_tile_density_clustering_assert.svh */
// Assertion macros for the grid tile density clustering block.
// Used by the port checker; depends on nothing else.
`ifndef GRID_TILE_DENSITY_CLUSTERING_ASSERT_SVH
`define GRID_TILE_DENSITY_CLUSTERING_ASSERT_SVH

// Same-cycle implication, disabled while reset is high
`define GTDC_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high
`define GTDC_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/gtdc_pkg.sv */
// Shared constants, codes and structs for the grid tile density clustering block.
// No dependencies; every other file but the assertion macro header imports it.
`timescale 1ns / 1ps

package gtdc_pkg;

  // Grid geometry
  localparam int GRID_W    = 64;
  localparam int GRID_H    = 64;
  localparam int NTILES    = GRID_W * GRID_H;
  localparam int COL_W     = $clog2(GRID_W);
  localparam int ROW_W     = $clog2(GRID_H);
  localparam int TILE_W    = $clog2(NTILES);
  localparam int SCAN_W    = $clog2(NTILES + 1);
  localparam int FIELD_W   = 6;

  // Field and register widths
  localparam int OP_W      = 2;
  localparam int STATUS_W  = 2;
  localparam int COORD_W   = 32;
  localparam int COUNT_W   = 16;
  localparam int LABEL_W   = 11;
  localparam int PREC_W    = 3;
  localparam int MINSZ_W   = 13;
  localparam int THRESH_W  = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  // Quantiser arithmetic
  localparam int FRAC_BITS = 16;
  localparam int PREC_MAX  = 6;
  localparam int SCALE_W   = 20;
  localparam int PROD_W    = COORD_W + SCALE_W;
  localparam int QUO_W     = PROD_W - FRAC_BITS;
  localparam int SVAL_W    = QUO_W + 1;
  localparam int POS_W     = SVAL_W + 1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [LABEL_W-1:0] LABEL_MAX = '1;

  typedef enum logic [OP_W-1:0] {
    OP_ADD  = 2'd0,
    OP_RUN  = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OUTSIDE   = 2'd1,
    ST_SATURATED = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRECISION  = 3'd0,
    CFG_THRESHOLD  = 3'd1,
    CFG_MIN_TILES  = 3'd2,
    CFG_ORIGIN_COL = 3'd3,
    CFG_ORIGIN_ROW = 3'd4
  } cfg_idx_e;

  // Request to the quantiser
  typedef struct packed {
    logic                      start;
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic [PREC_W-1:0]         precision;
    logic signed [COORD_W-1:0] origin_col;
    logic signed [COORD_W-1:0] origin_row;
  } quant_ctl_t;

  // Answer from the quantiser
  typedef struct packed {
    logic              done;
    logic              in_window;
    logic [TILE_W-1:0] tile;
  } quant_res_t;

endpackage

/* rtl/gtdc_item_if.sv */
// Input channel: one word per point, run or read request.
// Depends on gtdc_pkg.
`timescale 1ns / 1ps

interface gtdc_item_if import gtdc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           op;
  logic signed [COORD_W-1:0] x_coord;
  logic signed [COORD_W-1:0] y_coord;
  logic [FIELD_W-1:0]        tile_col;
  logic [FIELD_W-1:0]        tile_row;

  modport source (output valid, op, x_coord, y_coord, tile_col, tile_row, input ready);
  modport sink (input valid, op, x_coord, y_coord, tile_col, tile_row, output ready);
endinterface

/* rtl/gtdc_result_if.sv */
// Result channel: one word per accepted input word.
// Depends on gtdc_pkg.
`timescale 1ns / 1ps

interface gtdc_result_if import gtdc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [LABEL_W-1:0]  cluster_count;
  logic [LABEL_W-1:0]  tile_label;

  modport source (output valid, status, cluster_count, tile_label, input ready);
  modport sink (input valid, status, cluster_count, tile_label, output ready);
endinterface

/* rtl/gtdc_cfg_if.sv */
// Configuration write channel: register index and write data.
// Depends on gtdc_pkg.
`timescale 1ns / 1ps

interface gtdc_cfg_if import gtdc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/gtdc_quant.sv */
// Point quantiser: scales both coordinates by ten per step on one shift-add unit,
// truncates toward zero, offsets by the grid origin and checks the window.
// Depends on gtdc_pkg.
`timescale 1ns / 1ps

module gtdc_quant import gtdc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  quant_ctl_t ctl,
  output quant_res_t res
);

  typedef enum logic [3:0] {
    Q_IDLE   = 4'b0001,
    Q_SCALE  = 4'b0010,
    Q_SIGN   = 4'b0100,
    Q_OFFSET = 4'b1000
  } q_state_t;

  q_state_t                 state;
  logic [PROD_W-1:0]        prod;
  logic                     neg;
  logic [PREC_W-1:0]        steps;
  logic                     axis;
  logic signed [SVAL_W-1:0] sval;
  logic [COL_W-1:0]         col;
  logic                     col_in;

  logic [PREC_W-1:0]        p_eff;
  logic [COORD_W-1:0]       mag_x;
  logic [COORD_W-1:0]       mag_y;
  logic [QUO_W-1:0]         quo;
  logic signed [POS_W-1:0]  pos;
  logic                     pos_in;

  // Clamp precision, form magnitudes, the scaled quotient and the offset window position
  always_comb begin
    p_eff  = (ctl.precision > PREC_W'(PREC_MAX)) ? PREC_W'(PREC_MAX) : ctl.precision;
    mag_x  = ctl.x_coord[COORD_W-1] ? COORD_W'(-ctl.x_coord) : ctl.x_coord;
    mag_y  = ctl.y_coord[COORD_W-1] ? COORD_W'(-ctl.y_coord) : ctl.y_coord;
    quo    = prod[PROD_W-1:FRAC_BITS];
    pos    = POS_W'(sval) - POS_W'(axis ? ctl.origin_row : ctl.origin_col);
    pos_in = !pos[POS_W-1] && (pos < POS_W'(axis ? GRID_H : GRID_W));
  end

  // Sequencer: x axis first, then y
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= Q_IDLE;
      res.done <= 1'b0;
    end else begin
      // Flag the tile for one cycle once the y axis is offset
      res.done <= (state == Q_OFFSET) && axis;
      unique case (state)
        Q_IDLE: begin
          if (ctl.start) begin
            prod  <= PROD_W'(mag_x);
            neg   <= ctl.x_coord[COORD_W-1];
            steps <= '0;
            axis  <= 1'b0;
            state <= Q_SCALE;
          end
        end
        Q_SCALE: begin
          if (steps == p_eff) begin
            state <= Q_SIGN;
          end else begin
            prod  <= (prod << 3) + (prod << 1);
            steps <= steps + 1'b1;
          end
        end
        Q_SIGN: begin
          sval  <= neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
          state <= Q_OFFSET;
        end
        Q_OFFSET: begin
          if (!axis) begin
            col    <= pos[COL_W-1:0];
            col_in <= pos_in;
            prod   <= PROD_W'(mag_y);
            neg    <= ctl.y_coord[COORD_W-1];
            steps  <= '0;
            axis   <= 1'b1;
            state  <= Q_SCALE;
          end else begin
            res.in_window <= col_in && pos_in;
            res.tile      <= TILE_W'(pos[ROW_W-1:0]) * TILE_W'(GRID_W) + TILE_W'(col);
            state         <= Q_IDLE;
          end
        end
        default: state <= Q_IDLE;
      endcase
    end
  end

endmodule

/* rtl/grid_tile_density_clustering.sv */
// Channel  Dir  Payload                                         Accepted when
// item     in   op, x_coord, y_coord, tile_col, tile_row        valid && ready
// result   out  status, cluster_count, tile_label               valid && ready
// cfg      in   index, data                                     valid && ready
//
// One word in flight at a time; ready is high only when the sequencer is idle.
// Add point: quantised on the shared shift-add quantiser (precision held at six
// at most), then one count read-modify-write.
// Read: a lookup through the label memory. Run: a threshold sweep, a visit
// per grid tile, a neighbour search for each clustered tile and a label
// write for each of its member tiles.
// After reset a clearing pass of counts and labels keeps ready low.
// A stalled result holds; the next word is taken while a result still waits.
// Depends on gtdc_pkg, the channel interfaces and gtdc_quant.
`timescale 1ns / 1ps

module grid_tile_density_clustering import gtdc_pkg::*; (
  input logic            clk,
  input logic            rst,
  gtdc_item_if.sink      item,
  gtdc_result_if.source  result,
  gtdc_cfg_if.sink       cfg
);

  typedef enum logic [16:0] {
    S_CLEAR     = 17'h00001,
    S_IDLE      = 17'h00002,
    S_QUANT     = 17'h00004,
    S_CNT_RD    = 17'h00008,
    S_CNT_WR    = 17'h00010,
    S_SWEEP     = 17'h00020,
    S_SEED_RD   = 17'h00040,
    S_SEED_CHK  = 17'h00080,
    S_POP_RD    = 17'h00100,
    S_POP       = 17'h00200,
    S_NB_RD     = 17'h00400,
    S_NB_CHK    = 17'h00800,
    S_SIZE      = 17'h01000,
    S_LBL       = 17'h02000,
    S_LOOKUP_RD = 17'h04000,
    S_LOOKUP    = 17'h08000,
    S_FINISH    = 17'h10000
  } state_t;

  // Neighbour row offset in raster order
  function automatic logic signed [1:0] nb_dr(input logic [2:0] k);
    case (k)
      3'd0, 3'd1, 3'd2: nb_dr = -2'sd1;
      3'd3, 3'd4:       nb_dr = 2'sd0;
      default:          nb_dr = 2'sd1;
    endcase
  endfunction

  // Neighbour column offset in raster order
  function automatic logic signed [1:0] nb_dc(input logic [2:0] k);
    case (k)
      3'd0, 3'd3, 3'd5: nb_dc = -2'sd1;
      3'd1, 3'd6:       nb_dc = 2'sd0;
      default:          nb_dc = 2'sd1;
    endcase
  endfunction

  // Configuration registers
  logic [PREC_W-1:0]         precision;
  logic [THRESH_W-1:0]       threshold;
  logic [MINSZ_W-1:0]        min_tiles;
  logic signed [COORD_W-1:0] origin_col;
  logic signed [COORD_W-1:0] origin_row;

  // Sequencer registers
  state_t                    state;
  logic [SCAN_W-1:0]         scan;
  logic [SCAN_W-1:0]         sp;
  logic [SCAN_W-1:0]         members;
  logic [SCAN_W-1:0]         k;
  logic [2:0]                nb_k;
  logic [LABEL_W-1:0]        clusters;
  logic                      q_start;
  logic                      out_valid;

  // Payload registers
  logic signed [COORD_W-1:0] x_r;
  logic signed [COORD_W-1:0] y_r;
  logic [TILE_W-1:0]         tile_idx;
  logic [TILE_W-1:0]         rd_tile;
  logic [ROW_W-1:0]          cur_r;
  logic [COL_W-1:0]          cur_c;
  logic [TILE_W-1:0]         nb_tile;
  logic [LABEL_W-1:0]        cur_label;
  status_e                   res_status;
  logic [LABEL_W-1:0]        res_label;
  logic [STATUS_W-1:0]       out_status;
  logic [LABEL_W-1:0]        out_count;
  logic [LABEL_W-1:0]        out_label;

  // Memories and their ports
  logic [COUNT_W-1:0] cnt_mem [NTILES];
  logic [LABEL_W-1:0] lbl_mem [NTILES];
  logic [TILE_W-1:0]  stk_mem [NTILES];
  logic [TILE_W-1:0]  mbr_mem [NTILES];

  logic               cnt_we, lbl_we, stk_we, mbr_we;
  logic [TILE_W-1:0]  cnt_wa, cnt_ra, lbl_wa, lbl_ra, stk_wa, stk_ra, mbr_wa, mbr_ra;
  logic [COUNT_W-1:0] cnt_wd, cnt_rd;
  logic [LABEL_W-1:0] lbl_wd, lbl_rd;
  logic [TILE_W-1:0]  stk_wd, stk_rd, mbr_wd, mbr_rd;

  // Neighbour address
  logic signed [ROW_W+1:0] nr;
  logic signed [COL_W+1:0] nc;
  logic                    nb_in;
  logic [TILE_W-1:0]       nb_idx;
  logic [TILE_W-1:0]       scan_t;
  logic [TILE_W-1:0]       scan_m1;
  logic                    rd_inside;

  quant_ctl_t q_ctl;
  quant_res_t q_res;

  assign cfg.ready            = 1'b1;
  assign item.ready           = (state == S_IDLE);
  assign result.valid         = out_valid;
  assign result.status        = out_status;
  assign result.cluster_count = out_count;
  assign result.tile_label    = out_label;

  assign q_ctl = '{start: q_start, x_coord: x_r, y_coord: y_r, precision: precision,
                   origin_col: origin_col, origin_row: origin_row};

  gtdc_quant u_quant (
    .clk (clk),
    .rst (rst),
    .ctl (q_ctl),
    .res (q_res)
  );

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      precision  <= '0;
      threshold  <= THRESH_W'(1);
      min_tiles  <= MINSZ_W'(1);
      origin_col <= '0;
      origin_row <= '0;
    end else if (cfg.valid) begin
      unique case (cfg_idx_e'(cfg.index))
        CFG_PRECISION:  precision  <= cfg.data[PREC_W-1:0];
        CFG_THRESHOLD:  threshold  <= cfg.data[THRESH_W-1:0];
        CFG_MIN_TILES:  min_tiles  <= cfg.data[MINSZ_W-1:0];
        CFG_ORIGIN_COL: origin_col <= $signed(cfg.data);
        CFG_ORIGIN_ROW: origin_row <= $signed(cfg.data);
        default: ;
      endcase
    end
  end

  // Neighbour of the current tile, sweep addresses and the read window check
  always_comb begin
    nr        = $signed({2'b00, cur_r}) + (ROW_W+2)'(nb_dr(nb_k));
    nc        = $signed({2'b00, cur_c}) + (COL_W+2)'(nb_dc(nb_k));
    nb_in     = !nr[ROW_W+1] && (nr < (ROW_W+2)'(GRID_H)) &&
                !nc[COL_W+1] && (nc < (COL_W+2)'(GRID_W));
    nb_idx    = TILE_W'(nr[ROW_W-1:0]) * TILE_W'(GRID_W) + TILE_W'(nc[COL_W-1:0]);
    scan_t    = scan[TILE_W-1:0];
    scan_m1   = TILE_W'(scan - 1'b1);
    rd_inside = (32'(item.tile_col) < GRID_W) && (32'(item.tile_row) < GRID_H);
  end

  // Drive memory ports from the sequencer state
  always_comb begin
    cnt_we = 1'b0; cnt_wa = tile_idx; cnt_wd = '0; cnt_ra = tile_idx;
    lbl_we = 1'b0; lbl_wa = mbr_rd;   lbl_wd = '0; lbl_ra = rd_tile;
    stk_we = 1'b0; stk_wa = TILE_W'(sp); stk_wd = nb_tile; stk_ra = TILE_W'(sp - 1'b1);
    mbr_we = 1'b0; mbr_wa = TILE_W'(members); mbr_wd = stk_rd; mbr_ra = TILE_W'(k);
    unique case (state)
      S_CLEAR, S_SWEEP: begin
        cnt_ra = scan_t;
        if (scan != '0) begin
          cnt_we = 1'b1;
          cnt_wa = scan_m1;
          cnt_wd = ((state == S_CLEAR) || (cnt_rd < threshold)) ? '0 : cnt_rd;
          lbl_we = 1'b1;
          lbl_wa = scan_m1;
        end
      end
      S_CNT_WR: begin
        if (cnt_rd != COUNT_MAX) begin
          cnt_we = 1'b1;
          cnt_wd = cnt_rd + 1'b1;
        end
      end
      S_SEED_RD: cnt_ra = scan_t;
      S_SEED_CHK: begin
        if (cnt_rd != '0) begin
          cnt_we = 1'b1;
          cnt_wa = scan_t;
          stk_we = 1'b1;
          stk_wa = '0;
          stk_wd = scan_t;
        end
      end
      S_POP: mbr_we = 1'b1;
      S_NB_RD: cnt_ra = nb_idx;
      S_NB_CHK: begin
        if (cnt_rd != '0) begin
          cnt_we = 1'b1;
          cnt_wa = nb_tile;
          stk_we = 1'b1;
        end
      end
      S_LBL: begin
        if (k != '0) begin
          lbl_we = 1'b1;
          lbl_wd = cur_label;
        end
      end
      default: ;
    endcase
  end

  // Memory arrays with registered reads
  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    cnt_rd <= cnt_mem[cnt_ra];
  end

  always_ff @(posedge clk) begin
    if (lbl_we) lbl_mem[lbl_wa] <= lbl_wd;
    lbl_rd <= lbl_mem[lbl_ra];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    stk_rd <= stk_mem[stk_ra];
  end

  always_ff @(posedge clk) begin
    if (mbr_we) mbr_mem[mbr_wa] <= mbr_wd;
    mbr_rd <= mbr_mem[mbr_ra];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      scan      <= '0;
      sp        <= '0;
      members   <= '0;
      k         <= '0;
      nb_k      <= '0;
      clusters  <= '0;
      q_start   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // Pulse the quantiser start for an accepted add
      q_start <= (state == S_IDLE) && item.valid && (op_e'(item.op) == OP_ADD);
      // Drop the result word once taken, unless a new one loads now
      if (out_valid && result.ready && (state != S_FINISH)) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          if (scan == SCAN_W'(NTILES)) begin
            scan  <= '0;
            state <= S_IDLE;
          end else begin
            scan <= scan + 1'b1;
          end
        end
        S_IDLE: begin
          if (item.valid) begin
            res_status <= ST_OK;
            res_label  <= '0;
            unique case (op_e'(item.op))
              OP_ADD: begin
                x_r     <= item.x_coord;
                y_r     <= item.y_coord;
                state   <= S_QUANT;
              end
              OP_RUN: begin
                scan     <= '0;
                clusters <= '0;
                state    <= S_SWEEP;
              end
              OP_READ: begin
                rd_tile <= TILE_W'(item.tile_row) * TILE_W'(GRID_W) + TILE_W'(item.tile_col);
                state   <= rd_inside ? S_LOOKUP_RD : S_FINISH;
              end
              default: state <= S_FINISH;
            endcase
          end
        end
        S_QUANT: begin
          if (q_res.done) begin
            if (q_res.in_window) begin
              tile_idx <= q_res.tile;
              state    <= S_CNT_RD;
            end else begin
              res_status <= ST_OUTSIDE;
              state      <= S_FINISH;
            end
          end
        end
        S_CNT_RD: state <= S_CNT_WR;
        S_CNT_WR: begin
          if (cnt_rd == COUNT_MAX) res_status <= ST_SATURATED;
          state <= S_FINISH;
        end
        S_SWEEP: begin
          if (scan == SCAN_W'(NTILES)) begin
            scan  <= '0;
            state <= S_SEED_RD;
          end else begin
            scan <= scan + 1'b1;
          end
        end
        S_SEED_RD: state <= (scan == SCAN_W'(NTILES)) ? S_FINISH : S_SEED_CHK;
        S_SEED_CHK: begin
          if (cnt_rd != '0) begin
            sp      <= SCAN_W'(1);
            members <= '0;
            state   <= S_POP_RD;
          end else begin
            scan  <= scan + 1'b1;
            state <= S_SEED_RD;
          end
        end
        S_POP_RD: begin
          if (sp == '0) begin
            state <= S_SIZE;
          end else begin
            sp    <= sp - 1'b1;
            state <= S_POP;
          end
        end
        S_POP: begin
          cur_r   <= ROW_W'(stk_rd / GRID_W);
          cur_c   <= COL_W'(stk_rd % GRID_W);
          members <= members + 1'b1;
          nb_k    <= '0;
          state   <= S_NB_RD;
        end
        S_NB_RD: begin
          nb_tile <= nb_idx;
          if (nb_in) begin
            state <= S_NB_CHK;
          end else if (nb_k == 3'd7) begin
            state <= S_POP_RD;
          end else begin
            nb_k <= nb_k + 1'b1;
          end
        end
        S_NB_CHK: begin
          if (cnt_rd != '0) sp <= sp + 1'b1;
          if (nb_k == 3'd7) begin
            state <= S_POP_RD;
          end else begin
            nb_k  <= nb_k + 1'b1;
            state <= S_NB_RD;
          end
        end
        S_SIZE: begin
          if (32'(members) >= 32'(min_tiles)) begin
            if (clusters != LABEL_MAX) begin
              clusters  <= clusters + 1'b1;
              cur_label <= clusters + 1'b1;
            end else begin
              cur_label <= LABEL_MAX;
            end
          end else begin
            cur_label <= '0;
          end
          k     <= '0;
          state <= S_LBL;
        end
        S_LBL: begin
          k <= k + 1'b1;
          if (k == members) begin
            scan  <= scan + 1'b1;
            state <= S_SEED_RD;
          end
        end
        S_LOOKUP_RD: state <= S_LOOKUP;
        S_LOOKUP: begin
          res_label <= lbl_rd;
          state     <= S_FINISH;
        end
        S_FINISH: begin
          // Load the result word once the output register is free
          if (!out_valid || result.ready) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_count  <= clusters;
            out_label  <= res_label;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/gtdc_checker.sv */
// Port-level checker for the grid tile density clustering block, bound to the top.
// Depends on gtdc_pkg and grid_tile_density_clustering_assert.svh.
`timescale 1ns / 1ps
`include "grid_tile_density_clustering_assert.svh"

module gtdc_checker import gtdc_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                item_valid,
  input logic                item_ready,
  input logic                result_valid,
  input logic                result_ready,
  input logic [STATUS_W-1:0] status,
  input logic [LABEL_W-1:0]  cluster_count,
  input logic [LABEL_W-1:0]  tile_label
);

  // A held result keeps its payload
  `GTDC_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && !result_ready, result_valid && $stable(status) && $stable(cluster_count) && $stable(tile_label), "result word changed while stalled")

  // One word at a time: no accept straight after an accept
  `GTDC_ASSERT_NEXT(a_one_in_flight, clk, rst, item_valid && item_ready, !item_ready, "input ready again right after an accept")

  // A label never exceeds the clusters numbered by the last run
  `GTDC_ASSERT_IMP(a_label_range, clk, rst, result_valid && (tile_label != '0), tile_label <= cluster_count, "tile label beyond cluster count")

  // Only a read carries a label, and a read reports no error
  `GTDC_ASSERT_IMP(a_label_status, clk, rst, result_valid && (tile_label != '0), status == ST_OK, "labelled result with error status")

endmodule

bind grid_tile_density_clustering gtdc_checker u_gtdc_checker (
  .clk           (clk),
  .rst           (rst),
  .item_valid    (item.valid),
  .item_ready    (item.ready),
  .result_valid  (result.valid),
  .result_ready  (result.ready),
  .status        (result.status),
  .cluster_count (result.cluster_count),
  .tile_label    (result.tile_label)
);

/* tb/grid_tile_density_clustering_test.sv */
// Self-checking bench for grid_tile_density_clustering: point loading, runs and reads.
// Depends on gtdc_pkg, the gtdc channel interfaces and the block itself.
`timescale 1ns / 1ps

module grid_tile_density_clustering_test;
  import gtdc_pkg::*;

  localparam int LIMIT = 8_000_000;

  typedef struct {
    op_e                       op;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [FIELD_W-1:0]        col;
    logic [FIELD_W-1:0]        row;
  } word_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [LABEL_W-1:0]  cluster_count;
    logic [LABEL_W-1:0]  tile_label;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  gtdc_item_if   item ();
  gtdc_result_if result ();
  gtdc_cfg_if    cfg ();

  grid_tile_density_clustering dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item.sink),
    .result (result.source),
    .cfg    (cfg.sink)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mirror of the block's state and registers
  int unsigned  prec_q;
  int unsigned  thresh_q;
  int unsigned  minsz_q;
  longint       org_col_q;
  longint       org_row_q;
  int unsigned  density[NTILES];
  int unsigned  labels[NTILES];
  int unsigned  clusters;

  word_t   pending_words[$];
  answer_t expected_answers[$];
  int      fails = 0;

  function automatic longint scale_for(int unsigned p);
    longint s = 1;
    int unsigned lim;
    lim = (p > PREC_MAX) ? PREC_MAX : p;
    for (int i = 0; i < lim; i++) s = s * 10;
    return s;
  endfunction

  // Multiply by the scale, truncate toward zero
  function automatic longint quantise(logic signed [COORD_W-1:0] v, longint s);
    longint w;
    longint mag;
    w = v;
    mag = (w < 0) ? -w : w;
    mag = (mag * s) >> FRAC_BITS;
    return (w < 0) ? -mag : mag;
  endfunction

  // Threshold sweep, then 8-connected flood fill numbered in raster order
  function automatic void cluster_grid();
    int stack[$];
    int members[$];
    int t, r, c, nr, nc, nb;
    int unsigned lab;
    for (int i = 0; i < NTILES; i++) begin
      if (density[i] < thresh_q) density[i] = 0;
      labels[i] = 0;
    end
    clusters = 0;
    for (int seed = 0; seed < NTILES; seed++) begin
      if (density[seed] != 0) begin
        density[seed] = 0;
        stack = {seed};
        members = {};
        while (stack.size() > 0) begin
          t = stack.pop_back();
          r = t / GRID_W;
          c = t % GRID_W;
          members = {members, t};
          for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
              nr = r + dr;
              nc = c + dc;
              if ((dr != 0 || dc != 0) && nr >= 0 && nr < GRID_H && nc >= 0 && nc < GRID_W)
              begin
                nb = nr * GRID_W + nc;
                if (density[nb] != 0) begin
                  density[nb] = 0;
                  stack = {stack, nb};
                end
              end
            end
          end
        end
        lab = 0;
        if (members.size() >= minsz_q) begin
          if (clusters < LABEL_MAX) clusters++;
          lab = clusters;
        end
        foreach (members[k]) labels[members[k]] = lab;
      end
    end
  endfunction

  // Work out the answer to one accepted word and advance the mirror
  function automatic answer_t predict_answer(word_t w);
    answer_t a;
    longint s, col, row;
    int idx;
    a.status = ST_OK;
    a.tile_label = '0;
    case (w.op)
      OP_ADD: begin
        s = scale_for(prec_q);
        col = quantise(w.x, s) - org_col_q;
        row = quantise(w.y, s) - org_row_q;
        if (col < 0 || col >= GRID_W || row < 0 || row >= GRID_H) begin
          a.status = ST_OUTSIDE;
        end else begin
          idx = int'(row) * GRID_W + int'(col);
          if (density[idx] >= COUNT_MAX) a.status = ST_SATURATED;
          else density[idx]++;
        end
      end
      OP_RUN: cluster_grid();
      OP_READ: a.tile_label = LABEL_W'(labels[int'(w.row) * GRID_W + int'(w.col)]);
      default: ;
    endcase
    a.cluster_count = LABEL_W'(clusters);
    return a;
  endfunction

  // Driver: bursts of words with random gaps
  word_t cur_word;
  int    burst_left = 4;
  int    gap_left = 0;

  always @(posedge clk) begin
    logic nv;
    if (rst) begin
      item.valid <= 1'b0;
    end else begin
      nv = item.valid;
      if (item.valid && item.ready) begin
        expected_answers = {expected_answers, predict_answer(cur_word)};
        nv = 1'b0;
      end
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_words.size() > 0) begin
          cur_word = pending_words.pop_front();
          nv = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
      item.valid    <= nv;
      item.op       <= cur_word.op;
      item.x_coord  <= cur_word.x;
      item.y_coord  <= cur_word.y;
      item.tile_col <= cur_word.col;
      item.tile_row <= cur_word.row;
    end
  end

  // Monitor: stall on a pattern whose mode is picked anew at random
  int unsigned cyc = 0;
  int unsigned stall_mode = 0;

  always @(posedge clk) begin
    answer_t e;
    logic nr;
    cyc <= cyc + 1;
    if (cyc > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        if (expected_answers.size() == 0) begin
          fails++;
          $error("result word with nothing expected");
        end else begin
          e = expected_answers.pop_front();
          if (result.status !== e.status) begin
            fails++;
            $error("status: expected %0d, got %0d", e.status, result.status);
          end
          if (result.cluster_count !== e.cluster_count) begin
            fails++;
            $error("cluster_count: expected %0d, got %0d", e.cluster_count,
                   result.cluster_count);
          end
          if (result.tile_label !== e.tile_label) begin
            fails++;
            $error("tile_label: expected %0d, got %0d", e.tile_label, result.tile_label);
          end
        end
      end
      if (cyc % 64 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: nr = 1'b1;
        1: nr = 1'($urandom_range(0, 1));
        2: nr = (cyc % 8) != 3;
        default: nr = $urandom_range(0, 4) != 0;
      endcase
      result.ready <= nr;
    end
  end

  // Stimulus helpers
  task automatic queue_word(op_e op, logic signed [COORD_W-1:0] x,
                            logic signed [COORD_W-1:0] y);
    word_t w;
    w.op = op;
    w.x = x;
    w.y = y;
    w.col = FIELD_W'($urandom);
    w.row = FIELD_W'($urandom);
    pending_words = {pending_words, w};
  endtask

  // Coordinate whose tile lands near the given tile number
  function automatic logic signed [COORD_W-1:0] coord_for(longint t);
    longint v;
    longint fr;
    fr = $urandom_range(0, 65535);
    v = (t * 65536 + ((t >= 0) ? fr : -fr)) / scale_for(prec_q);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return COORD_W'(v);
  endfunction

  task automatic queue_tile(int gc, int gr);
    queue_word(OP_ADD, coord_for(org_col_q + gc), coord_for(org_row_q + gr));
  endtask

  task automatic queue_read(int gc, int gr);
    word_t w;
    w.op = OP_READ;
    w.x = $urandom;
    w.y = $urandom;
    w.col = FIELD_W'(gc);
    w.row = FIELD_W'(gr);
    pending_words = {pending_words, w};
  endtask

  task automatic wait_drained();
    while (pending_words.size() > 0 || item.valid || expected_answers.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Hold valid across back-to-back writes; set_regs drops it after the last
  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] d);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= d;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    case (idx)
      CFG_PRECISION:  prec_q = d[PREC_W-1:0];
      CFG_THRESHOLD:  thresh_q = d[THRESH_W-1:0];
      CFG_MIN_TILES:  minsz_q = d[MINSZ_W-1:0];
      CFG_ORIGIN_COL: org_col_q = $signed(d);
      default:        org_row_q = $signed(d);
    endcase
  endtask

  task automatic set_regs(int p, int th, int ms, int oc, int orr);
    write_reg(CFG_PRECISION, p);
    write_reg(CFG_THRESHOLD, th);
    write_reg(CFG_MIN_TILES, ms);
    write_reg(CFG_ORIGIN_COL, oc);
    write_reg(CFG_ORIGIN_ROW, orr);
    cfg.valid <= 1'b0;
  endtask

  // Mostly points around a few blobs, with runs, reads and noise mixed in
  task automatic random_batch(int n);
    int cx[4], cy[4];
    int pick, b;
    foreach (cx[i]) begin
      cx[i] = $urandom_range(0, GRID_W - 1);
      cy[i] = $urandom_range(0, GRID_H - 1);
    end
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      b = $urandom_range(0, 3);
      if (pick < 60) queue_tile(cx[b] + $urandom_range(0, 6) - 3, cy[b] + $urandom_range(0, 6) - 3);
      else if (pick < 68) queue_word(OP_ADD, $urandom, $urandom);
      else if (pick < 73) queue_word(OP_RUN, $urandom, $urandom);
      else if (pick < 85) queue_read(cx[b] + $urandom_range(0, 4) - 2, cy[b] + $urandom_range(0, 4) - 2);
      else if (pick < 96) queue_read($urandom_range(0, 63), $urandom_range(0, 63));
      else queue_word(OP_NONE, $urandom, $urandom);
    end
    queue_word(OP_RUN, $urandom, $urandom);
    for (int i = 0; i < 12; i++) queue_read(cx[i % 4], cy[i % 4]);
  endtask

  initial begin
    item.valid = 1'b0;
    item.op = OP_ADD;
    item.x_coord = '0;
    item.y_coord = '0;
    item.tile_col = '0;
    item.tile_row = '0;
    result.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = CFG_PRECISION;
    cfg.data = '0;
    prec_q = 0;
    thresh_q = 1;
    minsz_q = 1;
    org_col_q = 0;
    org_row_q = 0;
    clusters = 0;
    foreach (density[i]) begin
      density[i] = 0;
      labels[i] = 0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset settings, extremes, unused op, empty run, corner tiles
    queue_word(OP_NONE, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_read(0, 0);
    queue_word(OP_RUN, 0, 0);
    queue_word(OP_ADD, 32'sh7FFF_FFFF, 0);
    queue_word(OP_ADD, 32'sh8000_0000, 32'sh8000_0000);
    queue_word(OP_ADD, 32'shFFFF_8000, 32'sh0000_FFFF);
    queue_word(OP_ADD, 0, 0);
    queue_tile(63, 63);
    queue_tile(62, 62);
    queue_tile(63, 0);
    queue_tile(0, 63);
    queue_tile(64, 5);
    queue_word(OP_RUN, 0, 0);
    queue_read(0, 0);
    queue_read(63, 63);
    queue_read(62, 62);
    queue_read(63, 0);
    queue_read(0, 63);
    queue_read(1, 1);
    queue_word(OP_RUN, 0, 0);
    queue_read(63, 63);
    wait_drained();

    // Threshold and min size zero, window straddling negative tiles
    set_regs(0, 0, 0, -32, -20);
    random_batch(110);
    wait_drained();

    // Extreme settings, window at the far negative and positive corners
    set_regs(6, 65535, 4096, 32'h8000_0000, 32'h7FFF_FFC0);
    random_batch(50);
    wait_drained();
    set_regs(7, 0, 1, 32'h7FFF_FFC0, 32'h8000_0000);
    random_batch(50);
    wait_drained();

    // Middle settings with thresholds that bite
    for (int ph = 0; ph < 3; ph++) begin
      set_regs($urandom_range(1, 5), $urandom_range(1, 3), $urandom_range(1, 4),
               $urandom_range(0, 200) - 100, $urandom_range(0, 200) - 100);
      random_batch(80);
      wait_drained();
    end

    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* grid_tile_density_clustering.f */
+incdir+rtl
rtl/gtdc_pkg.sv
rtl/gtdc_item_if.sv
rtl/gtdc_result_if.sv
rtl/gtdc_cfg_if.sv
rtl/gtdc_quant.sv
rtl/grid_tile_density_clustering.sv
rtl/gtdc_checker.sv
tb/grid_tile_density_clustering_test.sv
